// File: hdl/i2cmb_pkg.sv
// Package of the I2C slave mailbox: command codes, field widths and word types.
// Depends on nothing; used by the channel interfaces and the top level.
package i2cmb_pkg;

    localparam int CMD_W  = 4;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 11;

    localparam int DEF_BUFFER_DEPTH = 1024;

    localparam logic [CMD_W-1:0] CMD_START   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_STOP    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RX      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_TX      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SETLEN  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_READ    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 4'd8;

    localparam logic [BYTE_W-1:0] FILLER = 8'hFF;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              transmitting;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic [LEN_W-1:0]  length;
    } t_in_word;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              nack;
        logic              message_ready;
        logic [LEN_W-1:0]  request_length;
        logic [BYTE_W-1:0] read_byte;
    } t_out_word;

endpackage

// File: hdl/i2cmb_in_if.sv
// Event channel of the I2C slave mailbox: valid, ready and one event word.
// Depends on i2cmb_pkg.
interface i2cmb_in_if;
    import i2cmb_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// File: hdl/i2cmb_out_if.sv
// Result channel of the I2C slave mailbox: valid, ready and one result word.
// Depends on i2cmb_pkg.
interface i2cmb_out_if;
    import i2cmb_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// File: hdl/i2c_slave_mailbox.sv
// Top level of the I2C slave mailbox: request and reply buffers with their counters.
// Depends on i2cmb_pkg, i2cmb_in_if and i2cmb_out_if.
//
// One event word is taken per clock cycle while the sink does not stall, and each
// gives one result word in the next cycle. Both buffers sit in synchronous
// memories with one read or write per event; the counters, the reply position and
// the ready flag sit in registers beside them, so nothing waits on a write-back.
// The single result register holds its word while the sink stalls, and a new
// event is taken in the cycle that word leaves. The buffers are not cleared after
// reset: a read of an entry never written returns whatever the memory holds.
module i2c_slave_mailbox #(
    parameter int BUFFER_DEPTH = i2cmb_pkg::DEF_BUFFER_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2cmb_in_if.sink          i_in,
    i2cmb_out_if.source       o_out
);
    import i2cmb_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int XW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(BUFFER_DEPTH);

    logic [BYTE_W-1:0] r_req_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rep_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_req_q, r_rep_q;

    logic [CW-1:0] r_req_cnt, n_req_cnt;
    logic [CW-1:0] r_rep_cnt, n_rep_cnt;
    logic [CW-1:0] r_rep_pos, n_rep_pos;
    logic          r_ready_flag, n_ready_flag;

    logic r_o_valid;
    logic r_tx_valid, n_tx_valid;
    logic r_tx_mem, n_tx_mem;
    logic r_nack, n_nack;
    logic r_rd_mem, n_rd_mem;

    logic          accept;
    logic          req_we, req_re, rep_we, rep_re;
    logic [AW-1:0] req_addr, rep_addr;
    logic [XW-1:0] idx_x, len_x, pos_x, rcnt_x, qcnt_x;
    logic          idx_ok;
    t_in_word      w;

    assign w       = i_in.word;
    assign i_in.ready = i_rst_n && (!r_o_valid || o_out.ready);
    assign accept  = i_in.valid && i_in.ready;

    assign idx_x  = XW'(w.index);
    assign len_x  = XW'(w.length);
    assign pos_x  = XW'(r_rep_pos);
    assign rcnt_x = XW'(r_rep_cnt);
    assign qcnt_x = XW'(r_req_cnt);
    assign idx_ok = idx_x < DEPTH_X;

    always_comb begin
        n_req_cnt    = r_req_cnt;
        n_rep_cnt    = r_rep_cnt;
        n_rep_pos    = r_rep_pos;
        n_ready_flag = r_ready_flag;
        n_tx_valid   = 1'b0;
        n_tx_mem     = 1'b0;
        n_nack       = 1'b0;
        n_rd_mem     = 1'b0;
        req_we       = 1'b0;
        req_re       = 1'b0;
        rep_we       = 1'b0;
        rep_re       = 1'b0;
        req_addr     = r_req_cnt[AW-1:0];
        rep_addr     = r_rep_pos[AW-1:0];
        case (w.cmd)
            CMD_START: begin
                if (w.transmitting) begin
                    n_tx_valid = 1'b1;
                    rep_addr   = '0;
                    if (r_rep_cnt != '0) begin
                        n_tx_mem  = 1'b1;
                        rep_re    = 1'b1;
                        n_rep_pos = CW'(1);
                    end else begin
                        n_rep_pos = '0;
                    end
                end else begin
                    n_ready_flag = 1'b0;
                    n_req_cnt    = '0;
                end
            end
            CMD_STOP: begin
                if (w.transmitting) begin
                    n_rep_cnt = '0;
                end else begin
                    n_ready_flag = 1'b1;
                end
            end
            CMD_RX: begin
                if (qcnt_x < DEPTH_X) begin
                    req_we    = 1'b1;
                    n_req_cnt = r_req_cnt + CW'(1);
                end else begin
                    n_nack = 1'b1;
                end
            end
            CMD_TX: begin
                n_tx_valid = 1'b1;
                if (pos_x < rcnt_x) begin
                    n_tx_mem  = 1'b1;
                    rep_re    = 1'b1;
                    n_rep_pos = r_rep_pos + CW'(1);
                end
            end
            CMD_TIMEOUT: begin
                n_nack     = 1'b1;
                n_tx_valid = 1'b1;
            end
            CMD_LOAD: begin
                rep_addr = idx_x[AW-1:0];
                rep_we   = idx_ok;
            end
            CMD_SETLEN: begin
                n_rep_cnt = (len_x > DEPTH_X) ? CW'(BUFFER_DEPTH) : CW'(len_x);
            end
            CMD_READ: begin
                req_addr = idx_x[AW-1:0];
                req_re   = idx_ok;
                n_rd_mem = idx_ok;
            end
            CMD_RELEASE: begin
                n_req_cnt    = '0;
                n_ready_flag = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && req_we) begin
            r_req_mem[req_addr] <= w.data;
        end
        if (accept && req_re) begin
            r_req_q <= r_req_mem[req_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && rep_we) begin
            r_rep_mem[rep_addr] <= w.data;
        end
        if (accept && rep_re) begin
            r_rep_q <= r_rep_mem[rep_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_cnt    <= '0;
            r_rep_cnt    <= '0;
            r_rep_pos    <= '0;
            r_ready_flag <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_req_cnt    <= n_req_cnt;
                r_rep_cnt    <= n_rep_cnt;
                r_rep_pos    <= n_rep_pos;
                r_ready_flag <= n_ready_flag;
                r_o_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx_valid <= n_tx_valid;
            r_tx_mem   <= n_tx_mem;
            r_nack     <= n_nack;
            r_rd_mem   <= n_rd_mem;
        end
    end

    assign o_out.valid               = r_o_valid;
    assign o_out.word.tx_valid       = r_tx_valid;
    assign o_out.word.tx_byte        = r_tx_mem ? r_rep_q : (r_tx_valid ? FILLER : '0);
    assign o_out.word.nack           = r_nack;
    assign o_out.word.message_ready  = r_ready_flag;
    assign o_out.word.request_length = LEN_W'(r_req_cnt);
    assign o_out.word.read_byte      = r_rd_mem ? r_req_q : '0;

endmodule

// File: dv/tb_i2c_slave_mailbox.sv
`timescale 1ns / 100ps
// Testbench of the I2C slave mailbox: drives bus and local events through the event channel,
// predicts every result word and checks it field by field on the result channel.
// Depends on i2cmb_pkg, i2cmb_in_if, i2cmb_out_if and i2c_slave_mailbox.
module tb_i2c_slave_mailbox;
    import i2cmb_pkg::*;

    localparam int DEPTH         = DEF_BUFFER_DEPTH;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int EVENT_TARGET  = 1350;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    logic i_clk;
    logic i_rst_n;

    i2cmb_in_if  ev_ch ();
    i2cmb_out_if res_ch ();

    i2c_slave_mailbox #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_ch),
        .o_out   (res_ch)
    );

    logic [BYTE_W-1:0] req_mem [DEPTH];
    logic [BYTE_W-1:0] rep_mem [DEPTH];
    bit               rep_known [DEPTH];
    int               req_top;
    logic [LEN_W-1:0] req_cnt;
    logic [LEN_W-1:0] rep_cnt;
    logic [LEN_W-1:0] rep_pos;
    logic             ready_q;

    t_out_word expected_results [$];
    int        mismatches  = 0;
    int        events_sent = 0;
    int        burst_left  = 0;
    bit        steady      = 0;
    int        hold_left   = 0;
    int        cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_word mailbox_result(input t_in_word w);
        t_out_word r;
        r = '0;
        case (w.cmd)
            CMD_START: begin
                if (w.transmitting) begin
                    r.tx_valid = 1'b1;
                    if (rep_cnt != 0) begin
                        r.tx_byte = rep_mem[0];
                        rep_pos   = LEN_W'(1);
                    end else begin
                        r.tx_byte = FILLER;
                        rep_pos   = '0;
                    end
                end else begin
                    ready_q = 1'b0;
                    req_cnt = '0;
                end
            end
            CMD_STOP: begin
                if (w.transmitting) rep_cnt = '0;
                else ready_q = 1'b1;
            end
            CMD_RX: begin
                if (req_cnt < DEPTH) begin
                    req_mem[req_cnt[IDX_W-1:0]] = w.data;
                    req_cnt = req_cnt + 1'b1;
                    if (int'(req_cnt) > req_top) req_top = int'(req_cnt);
                end else begin
                    r.nack = 1'b1;
                end
            end
            CMD_TX: begin
                r.tx_valid = 1'b1;
                if (rep_pos < rep_cnt) begin
                    r.tx_byte = rep_mem[rep_pos[IDX_W-1:0]];
                    rep_pos   = rep_pos + 1'b1;
                end else begin
                    r.tx_byte = FILLER;
                end
            end
            CMD_TIMEOUT: begin
                r.nack     = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte  = FILLER;
            end
            CMD_LOAD: begin
                if (int'(w.index) < DEPTH) begin
                    rep_mem[w.index]   = w.data;
                    rep_known[w.index] = 1'b1;
                end
            end
            CMD_SETLEN: rep_cnt = (w.length > DEPTH) ? LEN_W'(DEPTH) : w.length;
            CMD_READ: begin
                if (int'(w.index) < DEPTH) r.read_byte = req_mem[w.index];
            end
            CMD_RELEASE: begin
                req_cnt = '0;
                ready_q = 1'b0;
            end
            default: ;
        endcase
        r.message_ready  = ready_q;
        r.request_length = req_cnt;
        return r;
    endfunction

    function automatic t_in_word event_word(input logic [CMD_W-1:0] c);
        t_in_word w;
        w.cmd          = c;
        w.transmitting = 1'($urandom_range(0, 1));
        w.data         = BYTE_W'($urandom_range(0, 255));
        w.index        = IDX_W'($urandom_range(0, DEPTH - 1));
        w.length       = LEN_W'($urandom_range(0, 2047));
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [LEN_W-1:0] exp_v,
                                 input logic [LEN_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word exp;
        if (expected_results.size() == 0) begin
            $display("%0t: result word with none expected, got %p", $time, got);
            mismatches++;
        end else begin
            exp = expected_results.pop_front();
            compare_field("tx_valid", LEN_W'(exp.tx_valid), LEN_W'(got.tx_valid));
            compare_field("tx_byte", LEN_W'(exp.tx_byte), LEN_W'(got.tx_byte));
            compare_field("nack", LEN_W'(exp.nack), LEN_W'(got.nack));
            compare_field("message_ready", LEN_W'(exp.message_ready),
                          LEN_W'(got.message_ready));
            compare_field("request_length", exp.request_length, got.request_length);
            compare_field("read_byte", LEN_W'(exp.read_byte), LEN_W'(got.read_byte));
        end
    endtask

    task automatic push_word(input t_in_word w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady && $urandom_range(0, 3) != 0) begin
                ev_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        ev_ch.valid <= 1'b1;
        ev_ch.word  <= w;
        do @(posedge i_clk); while (ev_ch.ready !== 1'b1);
        expected_results.push_back(mailbox_result(w));
        events_sent++;
    endtask

    // Keep every buffer read on an entry already written.
    task automatic offer_event(input t_in_word w);
        t_in_word fix;
        int       p;
        if (w.cmd == CMD_READ && int'(w.index) >= req_top) begin
            if (req_top == 0) begin
                fix = event_word(CMD_RX);
                push_word(fix);
            end
            w.index = IDX_W'($urandom_range(0, req_top - 1));
        end
        p = -1;
        if (w.cmd == CMD_START && w.transmitting && rep_cnt != 0) p = 0;
        if (w.cmd == CMD_TX && rep_pos < rep_cnt) p = int'(rep_pos);
        if (p >= 0 && !rep_known[IDX_W'(p)]) begin
            fix       = event_word(CMD_LOAD);
            fix.index = IDX_W'(p);
            push_word(fix);
        end
        push_word(w);
    endtask

    task automatic offer_fields(input logic [CMD_W-1:0] c, input logic tr,
                                input logic [BYTE_W-1:0] d, input logic [IDX_W-1:0] idx,
                                input logic [LEN_W-1:0] len);
        t_in_word w;
        w.cmd          = c;
        w.transmitting = tr;
        w.data         = d;
        w.index        = idx;
        w.length       = len;
        offer_event(w);
    endtask

    task automatic wait_drained;
        ev_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        burst_left = 0;
    endtask

    task automatic test_idle_events;
        offer_fields(CMD_TX, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_START, 1'b1, 8'hFF, 10'h3FF, 11'h7FF);
        offer_fields(CMD_TIMEOUT, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_UNUSED_LO, 1'b1, 8'hFF, 10'h3FF, 11'h7FF);
        offer_fields(CMD_UNUSED_HI, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_STOP, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_RELEASE, 1'b1, 8'hFF, 10'h3FF, 11'h7FF);
        offer_fields(CMD_STOP, 1'b1, 8'h00, 10'h000, 11'h000);
    endtask

    task automatic test_exchange;
        offer_fields(CMD_START, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_RX, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_RX, 1'b0, 8'hFF, 10'h000, 11'h000);
        offer_fields(CMD_RX, 1'b0, 8'hA5, 10'h000, 11'h000);
        offer_fields(CMD_STOP, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_READ, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_READ, 1'b0, 8'h00, 10'h002, 11'h000);
        offer_fields(CMD_RELEASE, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_LOAD, 1'b0, 8'hFF, 10'h000, 11'h000);
        offer_fields(CMD_LOAD, 1'b0, 8'h00, 10'h3FF, 11'h000);
        offer_fields(CMD_LOAD, 1'b0, 8'h5A, 10'h001, 11'h000);
        offer_fields(CMD_SETLEN, 1'b0, 8'h00, 10'h000, 11'h7FF);
        offer_fields(CMD_SETLEN, 1'b0, 8'h00, 10'h000, 11'd2);
        offer_fields(CMD_START, 1'b1, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_TX, 1'b1, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_TX, 1'b1, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_STOP, 1'b1, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_TX, 1'b1, 8'h00, 10'h000, 11'h000);
    endtask

    task automatic test_overflow;
        t_in_word w;
        wait_drained();
        offer_fields(CMD_START, 1'b0, 8'h00, 10'h000, 11'h000);
        repeat (DEPTH + 4) begin
            w = event_word(CMD_RX);
            offer_event(w);
        end
        offer_fields(CMD_READ, 1'b0, 8'h00, 10'h3FF, 11'h000);
        offer_fields(CMD_READ, 1'b1, 8'hFF, 10'h000, 11'h7FF);
        offer_fields(CMD_TIMEOUT, 1'b1, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_STOP, 1'b0, 8'h00, 10'h000, 11'h000);
        offer_fields(CMD_RELEASE, 1'b0, 8'h00, 10'h000, 11'h000);
    endtask

    task automatic test_backpressure;
        t_in_word w;
        wait_drained();
        steady    = 1'b1;
        hold_left = HOLD_CYCLES;
        repeat (40) begin
            w = event_word(CMD_W'($urandom_range(0, 15)));
            offer_event(w);
        end
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic random_exchange;
        t_in_word w;
        int       kind;
        int       n;
        int       i;
        kind   = $urandom_range(0, 9);
        steady = ($urandom_range(0, 7) == 0);
        if (kind < 4) begin
            w = event_word(CMD_START);
            w.transmitting = 1'b0;
            offer_event(w);
            n = $urandom_range(0, 12);
            repeat (n) begin
                w = event_word(CMD_RX);
                offer_event(w);
            end
            if ($urandom_range(0, 7) == 0) begin
                w = event_word(CMD_TIMEOUT);
                offer_event(w);
            end
            w = event_word(CMD_STOP);
            w.transmitting = 1'b0;
            offer_event(w);
            repeat ($urandom_range(0, 3)) begin
                w = event_word(CMD_READ);
                offer_event(w);
            end
            if ($urandom_range(0, 1) != 0) begin
                w = event_word(CMD_RELEASE);
                offer_event(w);
            end
        end else if (kind < 8) begin
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++) begin
                w = event_word(CMD_LOAD);
                w.index = IDX_W'(i);
                offer_event(w);
            end
            w = event_word(CMD_SETLEN);
            if ($urandom_range(0, 5) != 0) w.length = LEN_W'(n);
            offer_event(w);
            w = event_word(CMD_START);
            w.transmitting = 1'b1;
            offer_event(w);
            repeat ($urandom_range(0, n + 2)) begin
                w = event_word(CMD_TX);
                offer_event(w);
            end
            w = event_word(CMD_STOP);
            w.transmitting = 1'b1;
            offer_event(w);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                w = event_word(CMD_W'($urandom_range(0, 15)));
                offer_event(w);
            end
        end
    endtask

    task automatic test_random;
        while (events_sent < EVENT_TARGET) random_exchange();
        steady = 1'b0;
    endtask

    initial begin
        int sink_mode;
        int sink_tick;
        sink_mode = 0;
        sink_tick = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) check_result(res_ch.word);
            sink_tick++;
            if (sink_tick % 97 == 0) sink_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= (sink_tick % 5 != 4);
                    default: res_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        ev_ch.valid = 1'b0;
        ev_ch.word  = '0;
        i_rst_n     = 1'b0;
        req_top     = 0;
        req_cnt     = '0;
        rep_cnt     = '0;
        rep_pos     = '0;
        ready_q     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_events();
        test_exchange();
        test_overflow();
        test_backpressure();
        test_random();

        ev_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
